FILE: design/slfe_pkg.sv
`timescale 1ns / 1ps

package slfe_pkg;

  // header layout
  localparam int unsigned HdrBytes = 4;

  // register reset values
  localparam logic [7:0]  SyncReset  = 8'hA5;
  localparam logic [15:0] LimitReset = 16'd4096;
  localparam logic [7:0]  TypeReset  = 8'h90;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_SYNC  = 2'd0,
    CFG_LIMIT = 2'd1,
    CFG_TYPE  = 2'd2
  } cfg_idx_e;

  // one result beat
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       first_of_frame;
    logic       last_of_frame;
    logic       empty_frame;
  } out_beat_t;

endpackage

FILE: design/sync_length_frame_extractor.sv
`timescale 1ns / 1ps

// Deframer for a byte stream of frames: sync byte, 16-bit big-endian length,
// type byte, then exactly length payload bytes.
// rx channel: one received byte per beat (rx_valid_i / rx_ready_o).
// out channel: one payload byte per beat with first/last marks; a zero-length
// frame of the accepted type gives one beat with empty_frame set and byte 0.
// Frames of other types and bytes discarded while hunting give no beat.
// cfg channel: index 0 sync value, 1 length limit, 2 accepted type; always
// ready, other indexes are ignored. Write only while the block is idle.
// A byte taken lands in the input register, and its result, if any, moves
// into the output register once that register is free or being read.
// Throughput: one byte per cycle while the receiver takes results, set by the
// single header compare and window shift between the input and output registers.
// Reset: hunting for a header, window empty, registers at their defaults.
// When the receiver stalls, the input register still takes one more byte,
// then rx_ready_o drops until the pending result is taken.

module sync_length_frame_extractor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  payload_byte_o,
  output logic        first_of_frame_o,
  output logic        last_of_frame_o,
  output logic        empty_frame_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // configuration registers
  logic [7:0]  sync_q;
  logic [15:0] limit_q;
  logic [7:0]  type_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q  <= slfe_pkg::SyncReset;
      limit_q <= slfe_pkg::LimitReset;
      type_q  <= slfe_pkg::TypeReset;
    end else if (cfg_valid_i) begin
      unique case (slfe_pkg::cfg_idx_e'(cfg_index_i))
        slfe_pkg::CFG_SYNC:  sync_q  <= cfg_data_i[7:0];
        slfe_pkg::CFG_LIMIT: limit_q <= cfg_data_i;
        slfe_pkg::CFG_TYPE:  type_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // input register and pipeline advance
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       adv;
  logic       step;

  assign adv        = !out_valid_o || out_ready_i;
  assign step       = in_valid_q && adv;
  assign rx_ready_o = !in_valid_q || adv;

  always_comb begin
    in_valid_d = in_valid_q;
    if (rx_valid_i && rx_ready_o) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_valid_i && rx_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // deframer state
  logic [7:0]  win_q [slfe_pkg::HdrBytes-1];
  logic [7:0]  win_d [slfe_pkg::HdrBytes-1];
  logic [1:0]  fill_q, fill_d;
  logic [15:0] left_q, left_d;
  logic        in_payload_q, in_payload_d;
  logic        deliver_q, deliver_d;
  logic        first_pend_q, first_pend_d;

  logic                res_valid;
  slfe_pkg::out_beat_t res;
  logic [15:0]         hdr_len;
  logic [15:0]         left_dec;

  assign hdr_len  = {win_q[1], win_q[2]};
  assign left_dec = left_q - 16'd1;

  // per-byte decision: payload count-down or header hunt
  always_comb begin
    win_d        = win_q;
    fill_d       = fill_q;
    left_d       = left_q;
    in_payload_d = in_payload_q;
    deliver_d    = deliver_q;
    first_pend_d = first_pend_q;
    res_valid    = 1'b0;
    res          = '0;
    if (step) begin
      if (in_payload_q) begin
        left_d       = left_dec;
        first_pend_d = 1'b0;
        if (left_dec == 16'd0) begin
          in_payload_d = 1'b0;
        end
        res_valid          = deliver_q;
        res.payload_byte   = in_byte_q;
        res.first_of_frame = first_pend_q;
        res.last_of_frame  = (left_dec == 16'd0);
      end else if (fill_q != 2'd3) begin
        win_d[fill_q] = in_byte_q;
        fill_d        = fill_q + 2'd1;
      end else if (win_q[0] != sync_q || hdr_len > limit_q) begin
        // bad header: drop the oldest byte, keep hunting
        win_d[0] = win_q[1];
        win_d[1] = win_q[2];
        win_d[2] = in_byte_q;
      end else begin
        fill_d = 2'd0;
        if (hdr_len == 16'd0) begin
          res_valid          = (in_byte_q == type_q);
          res.first_of_frame = 1'b1;
          res.last_of_frame  = 1'b1;
          res.empty_frame    = 1'b1;
        end else begin
          left_d       = hdr_len;
          in_payload_d = 1'b1;
          deliver_d    = (in_byte_q == type_q);
          first_pend_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= 2'd0;
      left_q       <= 16'd0;
      in_payload_q <= 1'b0;
      deliver_q    <= 1'b0;
      first_pend_q <= 1'b0;
    end else begin
      fill_q       <= fill_d;
      left_q       <= left_d;
      in_payload_q <= in_payload_d;
      deliver_q    <= deliver_d;
      first_pend_q <= first_pend_d;
    end
  end

  // header window bytes carry no reset
  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  // output register
  logic                out_valid_q, out_valid_d;
  slfe_pkg::out_beat_t out_q;

  assign out_valid_d = adv ? res_valid : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign payload_byte_o   = out_q.payload_byte;
  assign first_of_frame_o = out_q.first_of_frame;
  assign last_of_frame_o  = out_q.last_of_frame;
  assign empty_frame_o    = out_q.empty_frame;

`ifndef ASSERT_OFF
  // a payload phase always has bytes left to count
  a_left_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_payload_q |-> left_q != 16'd0)
    else $error("payload phase with zero bytes left");

  // first mark is only pending inside a payload phase
  a_first_in_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    first_pend_q |-> in_payload_q)
    else $error("first mark pending while hunting");

  // an empty-frame beat is a lone zero byte marked first and last
  a_empty_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.empty_frame) |->
      (out_q.first_of_frame && out_q.last_of_frame && out_q.payload_byte == 8'd0))
    else $error("malformed empty-frame beat");

  // the last payload byte ends the payload phase
  a_payload_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && in_payload_q && left_q == 16'd1) |=> !in_payload_q)
    else $error("payload phase did not end on its last byte");
`endif

endmodule
